FILE: rtl/rgb_hsv_color_classifier_core_macros.svh
// Assertion macros for the color classifier.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef RGB_HSV_COLOR_CLASSIFIER_CORE_MACROS_SVH
`define RGB_HSV_COLOR_CLASSIFIER_CORE_MACROS_SVH

// General property, sampled on the clock, off while reset is asserted.
`define RHCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Something that must hold on the cycle after a stalled output request.
`define RHCC_HOLD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (out_valid_o && !out_ready_i) |=> (prop)) else $error(msg);

`endif

FILE: rtl/rhcc_pkg.sv
package rhcc_pkg;

  // Width of each channel port
  localparam int unsigned InBits = 16;

  // Value thresholds, pre-scaled by 255 (V*255 = Max*100)
  localparam logic [14:0] VThr85 = 15'd21675;
  localparam logic [14:0] VThr80 = 15'd20400;
  localparam logic [14:0] VThr15 = 15'd3825;

  // Color names
  typedef enum logic [3:0] {
    CLR_WHITE  = 4'd0,
    CLR_GRAY   = 4'd1,
    CLR_BLACK  = 4'd2,
    CLR_RED    = 4'd3,
    CLR_ORANGE = 4'd4,
    CLR_BROWN  = 4'd5,
    CLR_YELLOW = 4'd6,
    CLR_GREEN  = 4'd7,
    CLR_BLUE   = 4'd8,
    CLR_PINK   = 4'd9,
    CLR_PURPLE = 4'd10
  } color_e;

  // One pixel reduced to its upper bytes
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

endpackage

FILE: rtl/rhcc_in_stage.sv
module rhcc_in_stage import rhcc_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [InBits-1:0] red_in_i,
  input  logic [InBits-1:0] green_in_i,
  input  logic [InBits-1:0] blue_in_i,
  input  logic              take_i,
  output logic              pix_valid_o,
  output pixel_t            pix_o
);

  logic   valid_q;
  pixel_t pix_q;

  // Stage frees up when empty or when its pixel moves on this cycle
  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Keep only the upper byte of each channel; bits above the width are dropped
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pix_q.red   <= red_in_i[CHANNEL_BITS-1 -: 8];
      pix_q.green <= green_in_i[CHANNEL_BITS-1 -: 8];
      pix_q.blue  <= blue_in_i[CHANNEL_BITS-1 -: 8];
    end
  end

  assign pix_valid_o = valid_q;
  assign pix_o       = pix_q;

endmodule

FILE: rtl/rhcc_classify.sv
module rhcc_classify import rhcc_pkg::*; (
  input  pixel_t pix_i,
  output color_e color_o
);

  logic [7:0]         r, g, b;
  logic [7:0]         mx, mn, d_raw, d;
  logic signed [18:0] rs, gs, bs, ds, p_s;
  logic [16:0]        p, dd;
  logic [14:0]        v100, s100, mx10, mx50, mx5;
  logic               s_le10, v_gt85, v_gt15;

  assign r = pix_i.red;
  assign g = pix_i.green;
  assign b = pix_i.blue;

  // Max, min and chroma; zero chroma counts as one
  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d_raw = mx - mn;
    d     = (d_raw == 8'd0) ? 8'd1 : d_raw;
  end

  assign rs = $signed({11'd0, r});
  assign gs = $signed({11'd0, g});
  assign bs = $signed({11'd0, b});
  assign ds = $signed({11'd0, d});

  // Hue scaled by chroma: H = p / d; ties pick red, then green
  always_comb begin
    if (mx == r) begin
      p_s = 19'sd60 * (gs - bs);
      if (p_s < 19'sd0) p_s = p_s + 19'sd360 * ds;
    end else if (mx == g) begin
      p_s = 19'sd60 * (bs - rs) + 19'sd120 * ds;
    end else begin
      p_s = 19'sd60 * (rs - gs) + 19'sd240 * ds;
    end
  end

  // p is never negative here and stays below 360*255
  assign p  = p_s[16:0];
  assign dd = {9'd0, d};

  // Saturation and value, cross-multiplied against Max and 255
  assign v100 = {7'd0, mx} * 15'd100;
  assign s100 = {7'd0, d} * 15'd100;
  assign mx10 = {7'd0, mx} * 15'd10;
  assign mx50 = {7'd0, mx} * 15'd50;
  assign mx5  = {7'd0, mx} * 15'd5;

  assign s_le10 = s100 <= mx10;
  assign v_gt85 = v100 > VThr85;
  assign v_gt15 = v100 > VThr15;

  // First match wins
  always_comb begin
    priority if (s_le10 && v_gt85) begin
      color_o = CLR_WHITE;
    end else if (s_le10 && v_gt15) begin
      color_o = CLR_GRAY;
    end else if (!v_gt15) begin
      color_o = CLR_BLACK;
    end else if (p < dd * 17'd30 || p >= dd * 17'd340) begin
      color_o = CLR_RED;
    end else if (p < dd * 17'd40) begin
      color_o = (s100 >= mx50 && v100 <= VThr80) ? CLR_BROWN : CLR_ORANGE;
    end else if (p < dd * 17'd65) begin
      color_o = CLR_YELLOW;
    end else if (p < dd * 17'd165) begin
      color_o = CLR_GREEN;
    end else if (p < dd * 17'd265) begin
      color_o = CLR_BLUE;
    end else if (p >= dd * 17'd300 && s100 > mx5 && v100 >= VThr80) begin
      color_o = CLR_PINK;
    end else begin
      color_o = CLR_PURPLE;
    end
  end

endmodule

FILE: rtl/rgb_hsv_color_classifier_core.sv
// Path from input request to color_code_o valid: input reg, then result reg.
// Throughput: one pixel per cycle unless stalled; the whole classification sits
// between the two registers; each stage holds one pixel under output backpressure.
// Reset: rst_ni is asynchronous, active low; it empties both stages, payload
// registers are not reset.
module rgb_hsv_color_classifier_core import rhcc_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [InBits-1:0] red_in_i,
  input  logic [InBits-1:0] green_in_i,
  input  logic [InBits-1:0] blue_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        color_code_o
);

  logic   pix_valid;
  pixel_t pix;
  logic   take;
  color_e color_d, color_q;
  logic   out_valid_q;

  // Result register frees up when empty or when its request is taken
  assign take = !out_valid_q || out_ready_i;

  rhcc_in_stage #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .take_i     (take),
    .pix_valid_o(pix_valid),
    .pix_o      (pix)
  );

  rhcc_classify u_classify (
    .pix_i  (pix),
    .color_o(color_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= pix_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pix_valid) begin
      color_q <= color_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign color_code_o = color_q;

endmodule

FILE: rtl/rhcc_checker.sv
`include "rgb_hsv_color_classifier_core_macros.svh"

module rhcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] color_code_o
);

  // Stalled result request stays up with the same color
  `RHCC_HOLD(a_out_valid_hold, out_valid_o, "stalled result request dropped")
  `RHCC_HOLD(a_out_code_hold, $stable(color_code_o), "stalled color code changed")

  // Input side only backs up when the result side is stalled
  `RHCC_ASSERT(a_ready_backpressure, !in_ready_o |-> (out_valid_o && !out_ready_i), "bad stall")

  // A fresh result must trace back to an accepted pixel, through the input register
  `RHCC_ASSERT(a_result_latency, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2), "orphan")

endmodule

bind rgb_hsv_color_classifier_core rhcc_checker u_checker (.*);

FILE: sim/rgb_hsv_color_classifier_core_test.sv
`timescale 1ns / 1ps

module rgb_hsv_color_classifier_core_test;
  import rhcc_pkg::*;

  localparam int ChanBits = 16;
  localparam int CycleLimit = 200000;
  localparam int LongHold = 40;
  localparam int RandomPixels = 1100;

  // Keeps the colors still owed by the block, oldest first
  class color_code_book;
    color_e pending_colors[$];
    int unsigned faults;

    // Color name of one pixel; every threshold is an exact cross-multiplication
    function color_e name_color(logic [InBits-1:0] r_raw, logic [InBits-1:0] g_raw,
                                logic [InBits-1:0] b_raw);
      int r, g, b, top, low, chroma, hue_num, val100, sat100;
      bit faint, bright, lit;
      r = int'(r_raw[ChanBits-1 -: 8]);
      g = int'(g_raw[ChanBits-1 -: 8]);
      b = int'(b_raw[ChanBits-1 -: 8]);
      top = r;
      low = r;
      if (g > top) top = g;
      if (b > top) top = b;
      if (g < low) low = g;
      if (b < low) low = b;
      chroma = top - low;
      if (chroma == 0) chroma = 1;
      // hue scaled by chroma; ties go red, then green, then blue
      if (top == r) begin
        hue_num = 60 * (g - b);
        if (hue_num < 0) hue_num += 360 * chroma;
      end else if (top == g) begin
        hue_num = 60 * (b - r) + 120 * chroma;
      end else begin
        hue_num = 60 * (r - g) + 240 * chroma;
      end
      val100 = top * 100;
      sat100 = chroma * 100;
      faint  = sat100 <= 10 * top;
      bright = val100 > 85 * 255;
      lit    = val100 > 15 * 255;
      if (faint && bright) return CLR_WHITE;
      if (faint && lit) return CLR_GRAY;
      if (!lit) return CLR_BLACK;
      if (hue_num < 30 * chroma || hue_num >= 340 * chroma) return CLR_RED;
      if (hue_num < 40 * chroma) begin
        if (sat100 >= 50 * top && val100 <= 80 * 255) return CLR_BROWN;
        return CLR_ORANGE;
      end
      if (hue_num < 65 * chroma) return CLR_YELLOW;
      if (hue_num < 165 * chroma) return CLR_GREEN;
      if (hue_num < 265 * chroma) return CLR_BLUE;
      if (hue_num >= 300 * chroma && sat100 > 5 * top && val100 >= 80 * 255) return CLR_PINK;
      return CLR_PURPLE;
    endfunction

    function void note_pixel(logic [InBits-1:0] r, logic [InBits-1:0] g,
                             logic [InBits-1:0] b);
      pending_colors.push_back(name_color(r, g, b));
    endfunction

    function void check_color(logic [3:0] got);
      color_e want;
      if (pending_colors.size() == 0) begin
        $display("%0t: color_code expected none, got %0d", $time, got);
        faults++;
      end else begin
        want = pending_colors.pop_front();
        if (got !== want) begin
          $display("%0t: color_code expected %0d (%s), got %0d", $time, want, want.name(), got);
          faults++;
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [InBits-1:0] red_in_i;
  logic [InBits-1:0] green_in_i;
  logic [InBits-1:0] blue_in_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [3:0]        color_code_o;

  color_code_book book = new();
  int idle_pct;
  bit long_hold_req;
  int cycle_count;

  rgb_hsv_color_classifier_core #(
    .CHANNEL_BITS(ChanBits)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .color_code_o(color_code_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Handshake monitor: log accepted pixels, check accepted colors
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) book.note_pixel(red_in_i, green_in_i, blue_in_i);
      if (out_valid_o && out_ready_i) book.check_color(color_code_o);
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    int hold;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        hold = LongHold;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_ready_i <= 1'b0;
        hold = $urandom_range(1, 5);
      end else begin
        out_ready_i <= 1'b1;
        hold = 0;
      end
      if (hold > 0) begin
        repeat (hold - 1) @(negedge clk_i);
        if (hold == LongHold) long_hold_req = 1'b0;
      end
    end
  end

  // Offer one pixel, called and returning at a falling edge
  task automatic send_pixel(input logic [InBits-1:0] r, input logic [InBits-1:0] g,
                            input logic [InBits-1:0] b, input bit may_idle);
    int gap;
    gap = (may_idle && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic int clamp_byte(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // Random pixel, biased toward grays, ties, dark pixels and threshold edges
  task automatic random_pixel(output logic [InBits-1:0] r, output logic [InBits-1:0] g,
                              output logic [InBits-1:0] b);
    int kind, top, low, mid, base;
    int edges[9];
    logic [7:0] rb, gb, bb;
    edges = '{0, 1, 38, 39, 203, 204, 216, 217, 255};
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      rb = 8'($urandom);
      gb = 8'($urandom);
      bb = 8'($urandom);
    end else if (kind < 55) begin
      // near-gray: low chroma around the saturation thresholds
      base = $urandom_range(0, 255);
      rb = 8'(clamp_byte(base + $urandom_range(0, 30) - 15));
      gb = 8'(clamp_byte(base + $urandom_range(0, 30) - 15));
      bb = 8'(clamp_byte(base + $urandom_range(0, 30) - 15));
    end else if (kind < 80) begin
      top = ($urandom_range(0, 1) == 0) ? edges[$urandom_range(0, 8)] : $urandom_range(0, 255);
      low = $urandom_range(0, top);
      mid = $urandom_range(low, top);
      case ($urandom_range(0, 5))
        0: begin rb = 8'(top); gb = 8'(mid); bb = 8'(low); end
        1: begin rb = 8'(top); gb = 8'(low); bb = 8'(mid); end
        2: begin rb = 8'(mid); gb = 8'(top); bb = 8'(low); end
        3: begin rb = 8'(low); gb = 8'(top); bb = 8'(mid); end
        4: begin rb = 8'(mid); gb = 8'(low); bb = 8'(top); end
        default: begin rb = 8'(low); gb = 8'(mid); bb = 8'(top); end
      endcase
    end else if (kind < 90) begin
      // channel ties on the maximum or minimum
      top = $urandom_range(0, 255);
      mid = $urandom_range(0, 255);
      case ($urandom_range(0, 3))
        0: begin rb = 8'(top); gb = 8'(top); bb = 8'(mid); end
        1: begin rb = 8'(top); gb = 8'(mid); bb = 8'(top); end
        2: begin rb = 8'(mid); gb = 8'(top); bb = 8'(top); end
        default: begin rb = 8'(top); gb = 8'(top); bb = 8'(top); end
      endcase
    end else begin
      rb = 8'($urandom_range(0, 45));
      gb = 8'($urandom_range(0, 45));
      bb = 8'($urandom_range(0, 45));
    end
    // lower bytes are don't-care for the block, so randomize them
    r = {rb, 8'($urandom)};
    g = {gb, 8'($urandom)};
    b = {bb, 8'($urandom)};
  endtask

  // Main sequence
  initial begin
    logic [InBits-1:0] preset[22][3];
    logic [InBits-1:0] r, g, b;
    preset = '{
      '{16'h0000, 16'h0000, 16'h0000},  // all zero: black
      '{16'hFFFF, 16'hFFFF, 16'hFFFF},  // all full: white
      '{16'h00FF, 16'h00FF, 16'h00FF},  // only ignored bits set
      '{16'hAAAA, 16'h5555, 16'hAAAA},
      '{16'h5555, 16'hAAAA, 16'h5555},
      '{16'hFF00, 16'hFA00, 16'hFA00},  // white
      '{16'h8000, 16'h7D00, 16'h7D00},  // gray
      '{16'h2700, 16'h2700, 16'h2700},  // gray just above black
      '{16'h2600, 16'h2600, 16'h2600},  // black edge
      '{16'hFF00, 16'h0000, 16'h0000},  // red
      '{16'hFF00, 16'h0000, 16'h0A00},  // red, hue wraps below zero
      '{16'hFF00, 16'h8C00, 16'h0000},  // orange
      '{16'h9600, 16'h5A00, 16'h1E00},  // brown
      '{16'hFF00, 16'hFF00, 16'h0000},  // yellow, red/green tie
      '{16'h0000, 16'hFF00, 16'h0000},  // green
      '{16'h3200, 16'hC800, 16'hC800},  // green/blue tie
      '{16'h0000, 16'h0000, 16'hFF00},  // blue
      '{16'hFF00, 16'h0000, 16'hC800},  // pink
      '{16'h8000, 16'h0000, 16'hFF00},  // purple
      '{16'hCB00, 16'h0000, 16'hC800},  // pink hue, value just under 80
      '{16'hC800, 16'hB400, 16'hB400},  // saturation exactly 10
      '{16'h0100, 16'h0000, 16'h0000}   // dim red: black
    };
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    red_in_i    = '0;
    green_in_i  = '0;
    blue_in_i   = '0;
    idle_pct    = 0;
    long_hold_req = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners
    idle_pct = 20;
    foreach (preset[i]) send_pixel(preset[i][0], preset[i][1], preset[i][2], 1'b1);

    // fill the pipe against a long output hold
    long_hold_req = 1'b1;
    repeat (12) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b, 1'b0);
    end

    // random traffic in segments of varying idle density, quiet tail
    for (int i = 0; i < RandomPixels; i++) begin
      if (i % 100 == 0) begin
        if (i >= RandomPixels - 200) idle_pct = 0;
        else case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 20;
          default: idle_pct = 50;
        endcase
      end
      random_pixel(r, g, b);
      send_pixel(r, g, b, 1'b1);
    end
    in_valid_i <= 1'b0;

    // drain
    while (book.pending_colors.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (book.faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
